// ----- rtl/tia_pkg.sv -----
// Shared constants, types and command/status bundles of the transaction ID allocator.
package tia_pkg;

	localparam int unsigned MAX_IDS   = 256;
	localparam int unsigned ID_W      = $clog2(MAX_IDS + 1);
	localparam int unsigned CNT_W     = $clog2(MAX_IDS + 1);
	localparam int unsigned PTR_W     = $clog2(MAX_IDS);
	localparam int unsigned CFG_IDX_W = 1;

	typedef logic [ID_W-1:0]  id_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PTR_W-1:0] ptr_t;

	localparam id_t  MAX_ID    = id_t'(MAX_IDS);
	localparam id_t  ID_ONE    = id_t'(1);
	localparam cnt_t FILL_FULL = cnt_t'(MAX_IDS);
	localparam ptr_t PTR_LAST  = ptr_t'(MAX_IDS - 1);

	localparam id_t RESET_MAX   = id_t'(256);
	localparam id_t RESET_START = id_t'(1);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b1;

	typedef struct packed {
		logic load_req;
		logic clear_step;
		logic fifo_pop;
		logic fifo_check;
		logic fset_commit;
		logic probe;
		logic test_commit;
		logic lookup;
		logic update_commit;
		logic fail;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic fifo_empty;
		logic exhausted;
		logic clr_last;
		logic probe_free;
		logic tries_zero;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/tia_ctrl.sv -----
// Controller state machine of the transaction ID allocator.
module tia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    op,
	input  tia_pkg::sts_t sts,
	output tia_pkg::cmd_t cmd,
	output logic          in_ready
);
	import tia_pkg::*;

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b00_0000_0001,
		ST_IDLE   = 10'b00_0000_0010,
		ST_FPOP   = 10'b00_0000_0100,
		ST_FCHK   = 10'b00_0000_1000,
		ST_FSET   = 10'b00_0001_0000,
		ST_PROBE  = 10'b00_0010_0000,
		ST_TEST   = 10'b00_0100_0000,
		ST_LOOKUP = 10'b00_1000_0000,
		ST_UPDATE = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op_in;

	assign op_in    = op_t'(op);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					unique case (op_in)
						OP_ALLOC: begin
							if (!sts.fifo_empty) begin
								state_d = ST_FPOP;
							end else if (sts.exhausted) begin
								cmd.fail = 1'b1;
								state_d  = ST_DONE;
							end else begin
								state_d = ST_PROBE;
							end
						end
						OP_RELEASE, OP_QUERY: begin
							state_d = ST_LOOKUP;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_FPOP: begin
				cmd.fifo_pop = 1'b1;
				state_d      = ST_FCHK;
			end
			ST_FCHK: begin
				cmd.fifo_check = 1'b1;
				state_d        = ST_FSET;
			end
			ST_FSET: begin
				cmd.fset_commit = 1'b1;
				state_d         = ST_DONE;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				state_d   = ST_TEST;
			end
			ST_TEST: begin
				cmd.test_commit = 1'b1;
				if (sts.probe_free) begin
					state_d = ST_DONE;
				end else if (sts.tries_zero) begin
					cmd.fail = 1'b1;
					state_d  = ST_DONE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update_commit = 1'b1;
				state_d           = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/tia_dp.sv -----
// Datapath of the transaction ID allocator: bitmap, reuse queue, rotor, counters, result register.
module tia_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tia_pkg::cmd_t                   cmd,
	output tia_pkg::sts_t                   sts,
	input  logic [1:0]                      op,
	input  tia_pkg::id_t                    id,
	input  logic                            cfg_we,
	input  logic [tia_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  tia_pkg::id_t                    cfg_wdata,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            status,
	output tia_pkg::id_t                    id_out,
	output logic                            busy_flag,
	output tia_pkg::id_t                    busy_count
);
	import tia_pkg::*;

	logic busy_mem [0:MAX_IDS];
	id_t  fifo_mem [0:MAX_IDS-1];

	id_t  max_q;
	id_t  rotor_q;
	cnt_t total_q;
	cnt_t fill_q;
	ptr_t head_q;
	ptr_t tail_q;
	id_t  clr_q;
	op_t  op_q;
	id_t  id_q;
	id_t  cand_q;
	id_t  tries_q;
	id_t  fifo_rd_q;
	logic busy_rd_q;
	logic rd_ok_q;
	logic rd_dflt_q;
	logic status_q;
	id_t  id_out_q;
	logic flag_q;
	logic out_valid_q;
	logic out_status_q;
	id_t  out_id_q;
	logic out_flag_q;
	id_t  out_count_q;

	id_t             eff_max;
	id_t             cur;
	id_t             rotor_next;
	id_t             start_rotor;
	logic [ID_W:0]   tries_sum;
	id_t             tries_init;
	logic            id_ok;
	logic            busy_now;
	logic            rd_en;
	id_t             rd_addr;
	logic            rd_dflt;
	logic            wr_en;
	id_t             wr_addr;
	logic            wr_data;
	logic            set_hit;
	logic            rel_hit;
	logic            push;

	assign eff_max     = (max_q == '0 || max_q > MAX_ID) ? MAX_ID : max_q;
	assign cur         = (rotor_q == '0 || rotor_q > eff_max) ? ID_ONE : rotor_q;
	assign rotor_next  = (cur == eff_max) ? ID_ONE : cur + ID_ONE;
	assign start_rotor = (cfg_wdata == '0 || cfg_wdata > eff_max) ? ID_ONE : cfg_wdata;
	assign tries_sum   = {1'b0, total_q} + (ID_W + 1)'(2);
	assign tries_init  = (tries_sum > {1'b0, eff_max}) ? eff_max : tries_sum[ID_W-1:0];
	assign id_ok       = (id_q != '0) && (id_q <= eff_max);
	assign busy_now    = rd_ok_q ? busy_rd_q : rd_dflt_q;

	assign set_hit = (cmd.fset_commit || cmd.test_commit) && !busy_now;
	assign rel_hit = cmd.update_commit && (op_q == OP_RELEASE) && busy_now;
	assign push    = rel_hit && (fill_q != FILL_FULL);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur;
		rd_dflt = 1'b0;
		priority if (cmd.fifo_check) begin
			rd_en   = (fifo_rd_q <= MAX_ID);
			rd_addr = fifo_rd_q;
			rd_dflt = 1'b1;
		end else if (cmd.probe) begin
			rd_en   = 1'b1;
			rd_addr = cur;
		end else if (cmd.lookup) begin
			rd_en   = id_ok;
			rd_addr = id_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cand_q;
		wr_data = 1'b0;
		priority if (cmd.clear_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (set_hit) begin
			wr_en   = 1'b1;
			wr_data = 1'b1;
		end else if (rel_hit) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			busy_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			busy_rd_q <= busy_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[tail_q] <= cand_q;
		end
		if (cmd.fifo_pop) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fifo_check || cmd.probe || cmd.lookup) begin
			rd_ok_q   <= rd_en;
			rd_dflt_q <= rd_dflt;
		end
		if (cmd.fifo_check) begin
			cand_q <= fifo_rd_q;
		end else if (cmd.probe) begin
			cand_q <= cur;
		end else if (cmd.lookup) begin
			cand_q <= id_q;
		end
		if (cmd.load_req) begin
			op_q    <= op_t'(op);
			id_q    <= id;
			tries_q <= tries_init;
		end else if (cmd.probe) begin
			tries_q <= tries_q - ID_ONE;
		end
		if (cmd.load_req) begin
			status_q <= cmd.fail;
		end else if (cmd.fail) begin
			status_q <= 1'b1;
		end
		if (cmd.load_req) begin
			id_out_q <= '0;
		end else if (cmd.fset_commit || (cmd.test_commit && !busy_now)) begin
			id_out_q <= cand_q;
		end
		if (cmd.load_req) begin
			flag_q <= 1'b0;
		end else if (cmd.update_commit && op_q == OP_QUERY) begin
			flag_q <= busy_now;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_id_q     <= id_out_q;
			out_flag_q   <= flag_q;
			out_count_q  <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= RESET_MAX;
			rotor_q     <= RESET_START;
			total_q     <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_MAX) begin
				max_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == CFG_START) begin
				rotor_q <= start_rotor;
			end else if (cmd.probe) begin
				rotor_q <= rotor_next;
			end
			if (set_hit) begin
				total_q <= total_q + cnt_t'(1);
			end else if (rel_hit) begin
				total_q <= total_q - cnt_t'(1);
			end
			if (cmd.fifo_pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + ptr_t'(1);
				fill_q <= fill_q - cnt_t'(1);
			end else if (push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + ptr_t'(1);
				fill_q <= fill_q + cnt_t'(1);
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + ID_ONE;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.fifo_empty = (fill_q == '0);
	assign sts.exhausted  = ({1'b0, total_q} >= {1'b0, eff_max});
	assign sts.clr_last   = (clr_q == MAX_ID);
	assign sts.probe_free = !busy_now;
	assign sts.tries_zero = (tries_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign id_out     = out_id_q;
	assign busy_flag  = out_flag_q;
	assign busy_count = out_count_q;

endmodule

// ----- rtl/transaction_id_allocator_core.sv -----
// Top level of the transaction ID allocator: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   op, id
//   out      source     out_valid / out_ready status, id_out, busy_flag, busy_count
//   cfg      sink       cfg_we                cfg_index, cfg_wdata
//
// Allocate from the reuse queue steps pop, check, set, done; allocate by counter search
// does k bitmap probes (k at most busy_count + 2), each a bitmap read plus a test, then
// done; release or query steps lookup, update, done; no-op or allocate with all IDs in use
// goes to done. After reset a clearing pass writes all 257 bitmap entries, in_ready low.
// A finished result sits in the output register; the next request is taken while it waits.
module transaction_id_allocator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      op,
	input  tia_pkg::id_t                    id,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output tia_pkg::id_t                    id_out,
	output logic                            busy_flag,
	output tia_pkg::id_t                    busy_count,
	input  logic                            cfg_we,
	input  logic [tia_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  tia_pkg::id_t                    cfg_wdata
);
	import tia_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	tia_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.id         (id),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.id_out     (id_out),
		.busy_flag  (busy_flag),
		.busy_count (busy_count)
	);

endmodule

// ----- rtl/tia_checker.sv -----
// Port-level assertions for the transaction ID allocator and their bind.
module tia_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            status,
	input tia_pkg::id_t                    id_out,
	input logic                            busy_flag,
	input tia_pkg::id_t                    busy_count
);
	import tia_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(id_out) && $stable(status)
			&& $stable(busy_count))
		else $error("result changed while stalled");

	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> id_out == '0 && !busy_flag)
		else $error("failed allocate carries an id or flag");

	a_flag_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_flag |-> id_out == '0 && !status)
		else $error("query result carries an id or failure");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_count <= MAX_ID && id_out <= MAX_ID)
		else $error("count or id out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in flight");

endmodule

bind transaction_id_allocator_core tia_checker u_tia_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.id_out     (id_out),
	.busy_flag  (busy_flag),
	.busy_count (busy_count)
);
